// ===== src/id_watch_list_filter_assert.svh =====
// Assertion helpers for the watch list filter.
// All checks are sampled on clk and held off while rst is high.
`ifndef ID_WATCH_LIST_FILTER_ASSERT_SVH
`define ID_WATCH_LIST_FILTER_ASSERT_SVH

// Same-cycle implication.
`define IWLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IWLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iwlf_pkg.sv =====
`timescale 1ns / 1ps

package iwlf_pkg;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FW_NONE     = 2'd0,
    FW_ALL      = 2'd1,
    FW_SELECTED = 2'd2,
    FW_NO_MATCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    FS_SILENT = 2'd0,
    FS_LIST   = 2'd1,
    FS_ALL    = 2'd2
  } filter_t;

  localparam logic [7:0] CC_CLEAR   = 8'd0;
  localparam logic [7:0] CC_ADD     = 8'd1;
  localparam logic [7:0] CC_REMOVE  = 8'd2;
  localparam logic [7:0] CC_SILENCE = 8'd3;
  localparam logic [7:0] CC_LIST    = 8'd4;
  localparam logic [7:0] CC_ALL     = 8'd5;

  localparam int COUNT_W = 5;

  // Result item, status in the lowest bits.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    filter_t            monitor;
    action_t            action;
    status_t            status;
  } result_t;

  localparam int RES_W    = $bits(result_t);
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== src/iwlf_out_reg.sv =====
`timescale 1ns / 1ps

// Output register: holds one result until the master side takes it.
module iwlf_out_reg
  import iwlf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             res,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  result_t data;
  logic    vld;

  assign free     = !vld || m_tready;
  assign m_tvalid = vld;
  assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (m_tready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// ===== src/id_watch_list_filter.sv =====
`timescale 1ns / 1ps
`include "id_watch_list_filter_assert.svh"

// Channel  Dir  tdata                                   tuser
// s_*      in   [7:0] control_code, [39:8] param_id      [0] mode
// m_*      out  [2:0] status, [4:3] forward_action,      -
//               [6:5] monitor_state, [11:7] entry_count
//
// Flow: an item without a search is accepted, then its result is made. A search
//   reads one entry a cycle until a hit or the end of the list (none on an
//   empty list); a removal then moves each entry after the hit down one place.
// Reset: synchronous; count cleared, list filtering on, list memory kept.
// Stalls: a waiting result sits in the output register while the next item
//   is taken; a finished item holds until that register is free.
module id_watch_list_filter
  import iwlf_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // [7:0] control_code, [39:8] param_id
  input  logic [0:0]          s_tuser,   // [0] mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // status, forward_action, monitor_state,
                                         // entry_count, then zero pad
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam logic [CNTW-1:0] CAP_C = CNTW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t          state;
  filter_t         filt;
  logic [CNTW-1:0] used;

  // Latched item.
  logic            mode_q;
  logic [7:0]      code_q;
  logic [31:0]     id_q;

  // Result under construction.
  status_t         res_status;
  action_t         res_action;

  // List memory and its read pipeline.
  logic [31:0]     mem [CAPACITY];
  logic [31:0]     rd_data;
  logic [CNTW-1:0] iss;      // next address to read
  logic            chk_vld;  // rd_data is valid this cycle
  logic [CNTW-1:0] chk_idx;  // address rd_data came from

  logic            rd_en;
  logic            match;
  logic            search_end;
  logic            shift_end;
  logic            we;
  logic [CNTW-1:0] waddr;
  logic [31:0]     wdata;

  logic            acc;
  logic            out_free;
  logic            out_load;
  result_t         res;
  logic [CNTW+COUNT_W-1:0] used_ext;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  assign match = (state == S_SEARCH) && chk_vld && (rd_data == id_q);
  assign rd_en = ((state == S_SEARCH) && (iss < used) && !match) ||
                 ((state == S_SHIFT) && (iss < used));
  assign search_end = (state == S_SEARCH) && (match || (!rd_en && !chk_vld));
  assign shift_end  = (state == S_SHIFT) && !rd_en && !chk_vld;

  // Write port: append on an add of a new ID with room left, move down one place while shifting.
  always_comb begin
    we    = 1'b0;
    waddr = used;
    wdata = id_q;
    if (state == S_SHIFT) begin
      we    = chk_vld;
      waddr = chk_idx - 1'b1;
      wdata = rd_data;
    end else if (search_end && !mode_q && (code_q == CC_ADD) && !match &&
                 (used < CAP_C)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[IDXW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[iss[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= iss;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      filt  <= FS_LIST;
      used  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (s_tuser[0]) begin
              case (filt)
                FS_LIST: state <= S_SEARCH;
                default: state <= S_FIN;
              endcase
            end else begin
              case (s_tdata[7:0])
                CC_CLEAR: begin
                  used  <= '0;
                  state <= S_FIN;
                end
                CC_ADD, CC_REMOVE: state <= S_SEARCH;
                CC_SILENCE: begin
                  filt  <= FS_SILENT;
                  state <= S_FIN;
                end
                CC_LIST: begin
                  filt  <= FS_LIST;
                  state <= S_FIN;
                end
                CC_ALL: begin
                  filt  <= FS_ALL;
                  state <= S_FIN;
                end
                default: state <= S_FIN;
              endcase
            end
          end
        end
        S_SEARCH: begin
          if (search_end) begin
            if (!mode_q && (code_q == CC_ADD) && !match && (used < CAP_C)) begin
              used <= used + 1'b1;
            end
            if (!mode_q && (code_q == CC_REMOVE) && match) begin
              state <= S_SHIFT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SHIFT: begin
          if (shift_end) begin
            used  <= used - 1'b1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload side of the sequencer: item latch, read address, result codes.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      iss <= iss + 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (acc) begin
          mode_q     <= s_tuser[0];
          code_q     <= s_tdata[7:0];
          id_q       <= s_tdata[39:8];
          iss        <= '0;
          if (s_tuser[0]) begin
            res_status <= ST_DONE;
            case (filt)
              FS_ALL:  res_action <= FW_ALL;
              default: res_action <= FW_NONE;
            endcase
          end else begin
            res_action <= FW_NONE;
            case (s_tdata[7:0])
              CC_CLEAR, CC_ADD, CC_REMOVE, CC_SILENCE, CC_LIST, CC_ALL:
                res_status <= ST_DONE;
              default: res_status <= ST_UNSUPPORTED;
            endcase
          end
        end
      end
      S_SEARCH: begin
        if (search_end) begin
          if (mode_q) begin
            res_action <= match ? FW_SELECTED : FW_NO_MATCH;
          end else if (code_q == CC_ADD) begin
            if (match) begin
              res_status <= ST_PRESENT;
            end else if (used >= CAP_C) begin
              res_status <= ST_FULL;
            end
          end else if (!match) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            // Tail starts one past the hit.
            iss <= chk_idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result assembly; the count field keeps the low bits of the count.
  assign used_ext     = {{COUNT_W{1'b0}}, used};
  assign res.count    = used_ext[COUNT_W-1:0];
  assign res.monitor  = filt;
  assign res.action   = res_action;
  assign res.status   = res_status;
  assign out_load     = (state == S_FIN) && out_free;

  iwlf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks.
  `IWLF_ASSERT_NOW(a_used_bound, 1'b1, used <= CAP_C, "entry count above capacity")
  `IWLF_ASSERT_NEXT(a_busy_after_accept, acc, !s_tready, "item taken while busy")
  `IWLF_ASSERT_NEXT(a_append_grows, (state == S_SEARCH) && we,
                    used == $past(used) + 1'b1, "append did not grow the list")
  `IWLF_ASSERT_NOW(a_shift_write_order, (state == S_SHIFT) && chk_vld,
                   chk_idx != '0, "shift wrote below the list start")

endmodule
